>>> hdl/ppfl_pkg.sv
// Shared constants, codes, control/status structs and helpers for the page free-list allocator.
package ppfl_pkg;

  // Sizing
  localparam int NUM_CPUS   = 8;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_SHIFT = 12;

  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int CNT_W  = PAGE_W + 1;
  localparam int LINK_W = PAGE_W + 1;
  localparam int ADDR_W = 32;
  localparam int BASE_W = ADDR_W + 1;
  localparam int POS_W  = ADDR_W + 2;
  localparam int FIDX_W = BASE_W - PAGE_SHIFT;

  localparam logic [BASE_W-1:0] PAGE_MASK  = BASE_W'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [POS_W-1:0]  PAGE_BYTES = POS_W'(64'd1 << PAGE_SHIFT);

  localparam logic [ADDR_W-1:0] LOW_RESET  = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] HIGH_RESET = 32'h8800_0000;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int CPUF_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_IW   = 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_LOW  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_HIGH = 1'b1;

  // Response source select
  localparam logic [1:0] RSEL_ZERO  = 2'd0;
  localparam logic [1:0] RSEL_EMPTY = 2'd1;
  localparam logic [1:0] RSEL_FREE  = 2'd2;
  localparam logic [1:0] RSEL_ALLOC = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       pop_read;
    logic       pop_commit;
    logic       free_commit;
    logic       init_push;
    logic       rsp_load;
    logic [1:0] rsp_sel;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             any_free;
    logic             free_ok;
    logic             init_more;
    logic             rsp_free;
  } sts_t;

  // cpu field modulo NUM_CPUS (narrow value, a few compare-subtract steps)
  function automatic logic [CPU_W-1:0] cpu_wrap(input logic [CPUF_W-1:0] c);
    logic [CPUF_W:0] v;
    v = {1'b0, c};
    for (int i = 0; i < 8; i++) begin
      if (32'(v) >= NUM_CPUS) v = v - (CPUF_W+1)'(NUM_CPUS);
    end
    return CPU_W'(v);
  endfunction

  // list number as the 3-bit result field
  function automatic logic [CPUF_W-1:0] cpu_field(input logic [CPU_W-1:0] c);
    logic [31:0] t;
    t = 32'(c);
    return t[CPUF_W-1:0];
  endfunction

  // region start rounded up to a page boundary
  function automatic logic [BASE_W-1:0] round_base(input logic [ADDR_W-1:0] low);
    return ({1'b0, low} + PAGE_MASK) & ~PAGE_MASK;
  endfunction

endpackage

>>> hdl/per_cpu_page_free_list.sv
// Top level of the per-CPU page free-list allocator with cross-list stealing.
//
//  channel | direction | handshake              | fields
//  --------+-----------+------------------------+-----------------------------------
//  req     | in        | req_valid / req_stall  | cmd, cpu, page_addr
//  rsp     | out       | rsp_valid / rsp_stall  | status, granted_addr, source_cpu
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  Alloc steps from accept to result through head pick, link memory read and head update.
//  Free and unknown commands are answered in the execute step; init pushes N pages one per cycle
//  through the single link memory write port. One beat in flight at a time.
//  A result waits in the output register; the next beat is taken meanwhile, and the
//  sequencer holds only when it must load a result while the register is still stalled.
//  Reset empties every list; the link memory needs no clearing pass.
module per_cpu_page_free_list (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [ppfl_pkg::CMD_W-1:0]    cmd,
  input  logic [ppfl_pkg::CPUF_W-1:0]   cpu,
  input  logic [ppfl_pkg::ADDR_W-1:0]   page_addr,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [ppfl_pkg::STATUS_W-1:0] status,
  output logic [ppfl_pkg::ADDR_W-1:0]   granted_addr,
  output logic [ppfl_pkg::CPUF_W-1:0]   source_cpu,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppfl_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ppfl_pkg::ADDR_W-1:0]   cfg_data
);
  import ppfl_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // registers are always writable
  assign cfg_ready = 1'b1;

  ppfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  ppfl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .cpu          (cpu),
    .page_addr    (page_addr),
    .rsp_stall    (rsp_stall),
    .rsp_valid    (rsp_valid),
    .status       (status),
    .granted_addr (granted_addr),
    .source_cpu   (source_cpu)
  );

endmodule

>>> hdl/ppfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> hdl/ppfl_ctrl.sv
// Command sequencer: steps alloc, free and init through the datapath.
module ppfl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ppfl_pkg::sts_t sts,
  output ppfl_pkg::ctl_t ctl
);
  import ppfl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_INIT = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign req_stall = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.rsp_sel = RSEL_ZERO;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.op)
          CMD_ALLOC: begin
            if (sts.any_free) begin
              ctl.pop_read = 1'b1;
              state_next   = S_POP;
            end else if (sts.rsp_free) begin
              ctl.rsp_load = 1'b1;
              ctl.rsp_sel  = RSEL_EMPTY;
              state_next   = S_IDLE;
            end
          end
          CMD_FREE: begin
            if (sts.rsp_free) begin
              ctl.free_commit = sts.free_ok;
              ctl.rsp_load    = 1'b1;
              ctl.rsp_sel     = RSEL_FREE;
              state_next      = S_IDLE;
            end
          end
          CMD_INIT: begin
            state_next = S_INIT;
          end
          default: begin
            if (sts.rsp_free) begin
              ctl.rsp_load = 1'b1;
              state_next   = S_IDLE;
            end
          end
        endcase
      end
      S_POP: begin
        if (sts.rsp_free) begin
          ctl.pop_commit = 1'b1;
          ctl.rsp_load   = 1'b1;
          ctl.rsp_sel    = RSEL_ALLOC;
          state_next     = S_IDLE;
        end
      end
      S_INIT: begin
        if (sts.init_more) begin
          ctl.init_push = 1'b1;
        end else if (sts.rsp_free) begin
          ctl.rsp_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hdl/ppfl_dp.sv
// Datapath: region registers, list heads, link memory, checks and result register.
module ppfl_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ppfl_pkg::ctl_t                    ctl,
  output ppfl_pkg::sts_t                    sts,
  input  logic                              cfg_valid,
  input  logic [ppfl_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [ppfl_pkg::ADDR_W-1:0]       cfg_data,
  input  logic [ppfl_pkg::CMD_W-1:0]        cmd,
  input  logic [ppfl_pkg::CPUF_W-1:0]       cpu,
  input  logic [ppfl_pkg::ADDR_W-1:0]       page_addr,
  input  logic                              rsp_stall,
  output logic                              rsp_valid,
  output logic [ppfl_pkg::STATUS_W-1:0]     status,
  output logic [ppfl_pkg::ADDR_W-1:0]       granted_addr,
  output logic [ppfl_pkg::CPUF_W-1:0]       source_cpu
);
  import ppfl_pkg::*;

  logic [ADDR_W-1:0] region_low, region_high;
  logic [BASE_W-1:0] base;

  logic [PAGE_W-1:0]   list_head [NUM_CPUS];
  logic [NUM_CPUS-1:0] list_nonempty;

  logic [CMD_W-1:0]  op_cmd;
  logic [ADDR_W-1:0] op_addr;
  logic [CPU_W-1:0]  act_cpu;
  logic              alloc_any;

  logic [CNT_W-1:0] init_cnt;
  logic [POS_W-1:0] init_pos;

  logic [CPU_W-1:0]  req_cpu, low_cpu;
  logic [PAGE_W-1:0] head_cur;
  logic              ne_cur;
  logic [BASE_W-1:0] free_diff;
  logic [FIDX_W-1:0] free_idx;
  logic              free_ok;
  logic              init_more;

  logic              ram_we;
  logic [PAGE_W-1:0] ram_waddr;
  logic [LINK_W-1:0] ram_wdata, ram_rdata;

  // configuration registers; base kept pre-rounded
  always_ff @(posedge clk) begin
    if (rst) begin
      region_low  <= LOW_RESET;
      region_high <= HIGH_RESET;
      base        <= round_base(LOW_RESET);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_LOW) begin
        region_low <= cfg_data;
        base       <= round_base(cfg_data);
      end else begin
        region_high <= cfg_data;
      end
    end
  end

  // source list pick: own list, else lowest non-empty one
  assign req_cpu = cpu_wrap(cpu);
  always_comb begin
    low_cpu = req_cpu;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (list_nonempty[i]) low_cpu = CPU_W'(i);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_cmd    <= cmd;
      op_addr   <= page_addr;
      alloc_any <= |list_nonempty;
      if (cmd == CMD_ALLOC && !list_nonempty[req_cpu]) act_cpu <= low_cpu;
      else                                              act_cpu <= req_cpu;
    end
  end

  assign head_cur = list_head[act_cpu];
  assign ne_cur   = list_nonempty[act_cpu];

  // free address checks
  assign free_diff = {1'b0, op_addr} - base;
  assign free_idx  = free_diff[BASE_W-1:PAGE_SHIFT];
  assign free_ok   = (op_addr[PAGE_SHIFT-1:0] == '0) &&
                     (op_addr >= region_low) && (op_addr < region_high) &&
                     (free_idx < FIDX_W'(NUM_PAGES));

  // init walk: page counter and byte position
  assign init_more = (init_cnt < CNT_W'(NUM_PAGES)) &&
                     ((init_pos + PAGE_BYTES) <= {2'b00, region_high});

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      init_cnt <= '0;
      init_pos <= {1'b0, base};
    end else if (ctl.init_push) begin
      init_cnt <= init_cnt + CNT_W'(1);
      init_pos <= init_pos + PAGE_BYTES;
    end
  end

  // link memory: {successor valid, successor page}
  assign ram_we    = ctl.free_commit | ctl.init_push;
  assign ram_waddr = ctl.init_push ? init_cnt[PAGE_W-1:0] : free_idx[PAGE_W-1:0];
  assign ram_wdata = {ne_cur, head_cur};

  ppfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.pop_read),
    .raddr (head_cur),
    .rdata (ram_rdata)
  );

  // list heads: push on free/init, pop on alloc
  always_ff @(posedge clk) begin
    if (rst) begin
      list_nonempty <= '0;
      for (int i = 0; i < NUM_CPUS; i++) list_head[i] <= '0;
    end else begin
      priority if (ctl.free_commit) begin
        list_head[act_cpu]     <= free_idx[PAGE_W-1:0];
        list_nonempty[act_cpu] <= 1'b1;
      end else if (ctl.init_push) begin
        list_head[act_cpu]     <= init_cnt[PAGE_W-1:0];
        list_nonempty[act_cpu] <= 1'b1;
      end else if (ctl.pop_commit) begin
        list_head[act_cpu]     <= ram_rdata[LINK_W-1] ? ram_rdata[PAGE_W-1:0] : '0;
        list_nonempty[act_cpu] <= ram_rdata[LINK_W-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (ctl.rsp_load) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.rsp_load) begin
      unique case (ctl.rsp_sel)
        RSEL_ALLOC: begin
          status       <= ST_OK;
          granted_addr <= base[ADDR_W-1:0] + (ADDR_W'(head_cur) << PAGE_SHIFT);
          source_cpu   <= cpu_field(act_cpu);
        end
        RSEL_EMPTY: begin
          status       <= ST_EMPTY;
          granted_addr <= '0;
          source_cpu   <= '0;
        end
        RSEL_FREE: begin
          status       <= free_ok ? ST_OK : ST_BAD;
          granted_addr <= '0;
          source_cpu   <= '0;
        end
        default: begin
          status       <= ST_OK;
          granted_addr <= '0;
          source_cpu   <= '0;
        end
      endcase
    end
  end

  // status to controller
  assign sts.op        = op_cmd;
  assign sts.any_free  = alloc_any;
  assign sts.free_ok   = free_ok;
  assign sts.init_more = init_more;
  assign sts.rsp_free  = !rsp_valid || !rsp_stall;

endmodule

>>> hdl/ppfl_checker.sv
// Port-level checks for the page free-list allocator, bound to the top level.
module ppfl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [ppfl_pkg::STATUS_W-1:0] status,
  input logic [ppfl_pkg::ADDR_W-1:0]   granted_addr,
  input logic [ppfl_pkg::CPUF_W-1:0]   source_cpu
);
  import ppfl_pkg::*;

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
      $stable(granted_addr) && $stable(source_cpu))
    else $error("result beat changed while stalled");

  // one beat in work at a time: intake closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second beat accepted while one is in work");

  // only a successful alloc carries an address or a source list
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> granted_addr == '0 && source_cpu == '0)
    else $error("failed result carries a grant");

  // granted pages are page aligned, status codes stay in range
  a_grant_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> granted_addr[PAGE_SHIFT-1:0] == '0 &&
      (status == ST_OK || status == ST_EMPTY || status == ST_BAD))
    else $error("bad grant alignment or status code");

endmodule

bind per_cpu_page_free_list ppfl_checker u_ppfl_checker (.*);

>>> tb/sv/page_grant_checker.sv
// Checker for the per-CPU page allocator: tracks the free lists and checks every result beat.
`timescale 1ns / 100ps
module page_grant_checker
  import ppfl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [CPUF_W-1:0]   cpu,
  input  logic [ADDR_W-1:0]   page_addr,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  logic [STATUS_W-1:0] status,
  input  logic [ADDR_W-1:0]   granted_addr,
  input  logic [CPUF_W-1:0]   source_cpu,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data,
  output int                  pending,
  output int                  failures
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [CPUF_W-1:0]   src;
  } grant_t;

  localparam longint unsigned PG_BYTES = 64'd1 << PAGE_SHIFT;

  // Shadow of the region registers and the free lists
  logic [ADDR_W-1:0] low_q;
  logic [ADDR_W-1:0] high_q;
  bit [PAGE_W-1:0]   head_idx  [NUM_CPUS];
  bit                head_live [NUM_CPUS];
  bit [PAGE_W-1:0]   link_idx  [NUM_PAGES];
  bit                link_live [NUM_PAGES];

  grant_t owed_grants [$];
  int     fail_cnt = 0;

  assign failures = fail_cnt;

  function automatic longint unsigned region_base();
    return ({32'b0, low_q} + PG_BYTES - 1) & ~(PG_BYTES - 1);
  endfunction

  // LIFO push of one page index onto a list
  function automatic void stack_page(int c, int idx);
    link_idx[idx]  = head_idx[c];
    link_live[idx] = head_live[c];
    head_idx[c]    = PAGE_W'(idx);
    head_live[c]   = 1'b1;
  endfunction

  // pop the head of a non-empty list
  function automatic int take_page(int c);
    int idx;
    idx = int'(head_idx[c]);
    if (link_live[idx]) begin
      head_idx[c] = link_idx[idx];
    end else begin
      head_idx[c]  = '0;
      head_live[c] = 1'b0;
    end
    return idx;
  endfunction

  // Work out the result of one request beat and update the lists
  function automatic grant_t serve_request(logic [CMD_W-1:0] op, logic [CPUF_W-1:0] who,
                                           logic [ADDR_W-1:0] where);
    grant_t          g;
    int              c;
    int              from;
    int              idx;
    int              i;
    longint unsigned base;
    longint unsigned off;
    longint unsigned p;
    g    = '0;
    c    = int'(who) % NUM_CPUS;
    base = region_base();
    case (op)
      CMD_ALLOC: begin
        from = -1;
        if (head_live[c]) begin
          from = c;
        end else begin
          for (i = 0; i < NUM_CPUS; i++)
            if (from < 0 && i != c && head_live[i]) from = i;
        end
        if (from < 0) begin
          g.status = ST_EMPTY;
        end else begin
          idx    = take_page(from);
          g.addr = 32'(base + (longint'(idx) << PAGE_SHIFT));
          g.src  = CPUF_W'(from);
        end
      end
      CMD_FREE: begin
        if (where[PAGE_SHIFT-1:0] != '0 || where < low_q || where >= high_q) begin
          g.status = ST_BAD;
        end else begin
          off = ({32'b0, where} - base) >> PAGE_SHIFT;
          if (off >= NUM_PAGES) g.status = ST_BAD;
          else stack_page(c, int'(off));
        end
      end
      CMD_INIT: begin
        // ascending pages, so the lowest ends up deepest
        p   = base;
        idx = 0;
        while (idx < NUM_PAGES && p + PG_BYTES <= {32'b0, high_q}) begin
          stack_page(c, idx);
          idx++;
          p += PG_BYTES;
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic void compare(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want_v, got_v);
      fail_cnt++;
    end
  endfunction

  // Watch all three channels at the clock edge
  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      low_q  = LOW_RESET;
      high_q = HIGH_RESET;
      for (int c = 0; c < NUM_CPUS; c++) begin
        head_idx[c]  = '0;
        head_live[c] = 1'b0;
      end
      owed_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOW:  low_q = cfg_data;
          CFG_HIGH: high_q = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall)
        owed_grants.push_back(serve_request(cmd, cpu, page_addr));
      if (rsp_valid && !rsp_stall) begin
        if (owed_grants.size() == 0) begin
          $display("%0t: result beat with none owed, status %0d addr %h source %0d",
                   $time, status, granted_addr, source_cpu);
          fail_cnt++;
        end else begin
          want = owed_grants.pop_front();
          compare("status", 32'(want.status), 32'(status));
          compare("granted_addr", want.addr, granted_addr);
          compare("source_cpu", 32'(want.src), 32'(source_cpu));
        end
      end
    end
    pending <= owed_grants.size();
  end

endmodule

>>> tb/sv/tb_per_cpu_page_free_list.sv
// Top of the page allocator testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 100ps
module tb_per_cpu_page_free_list;
  import ppfl_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_NOP     = 2'd3;
  localparam longint unsigned   PG_BYTES    = 64'd1 << PAGE_SHIFT;
  localparam int                CYCLE_LIMIT = 1_000_000;

  logic                clk = 1'b0;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic [CMD_W-1:0]    cmd;
  logic [CPUF_W-1:0]   cpu;
  logic [ADDR_W-1:0]   page_addr;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted_addr;
  logic [CPUF_W-1:0]   source_cpu;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index;
  logic [ADDR_W-1:0]   cfg_data;
  int                  pending;
  int                  failures;

  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  cycles = 0;
  logic [ADDR_W-1:0]   cur_low = LOW_RESET;
  logic [ADDR_W-1:0]   cur_high = HIGH_RESET;

  per_cpu_page_free_list u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .cmd(cmd), .cpu(cpu), .page_addr(page_addr),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .granted_addr(granted_addr), .source_cpu(source_cpu),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  page_grant_checker u_chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .cmd(cmd), .cpu(cpu), .page_addr(page_addr),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .granted_addr(granted_addr), .source_cpu(source_cpu),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .failures(failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk)
    rsp_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);

  // run-away guard
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic longint unsigned first_page(logic [ADDR_W-1:0] lo);
    return ({32'b0, lo} + PG_BYTES - 1) & ~(PG_BYTES - 1);
  endfunction

  // whole pages in the current region, capped
  function automatic int region_pages();
    longint unsigned b;
    b = first_page(cur_low);
    if ({32'b0, cur_high} <= b) return 0;
    if ((({32'b0, cur_high} - b) >> PAGE_SHIFT) > 64'd1048576) return 1048576;
    return int'(({32'b0, cur_high} - b) >> PAGE_SHIFT);
  endfunction

  // mostly pages in or just past the region, some misaligned
  function automatic logic [ADDR_W-1:0] free_target(int span);
    longint unsigned b;
    int              n;
    b = first_page(cur_low);
    n = (span > 64) ? 64 : span;
    if ($urandom_range(7) == 0)
      return 32'(b + (longint'($urandom_range(n)) << PAGE_SHIFT))
             + $urandom_range(int'(PG_BYTES) - 1, 1);
    return 32'(b + (longint'($urandom_range(n + 1)) << PAGE_SHIFT));
  endfunction

  // One request beat, with random sender gaps in front
  task automatic issue_request(input logic [CMD_W-1:0] op, input logic [CPUF_W-1:0] who,
                               input logic [ADDR_W-1:0] where);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd       <= op;
    cpu       <= who;
    page_addr <= where;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [ADDR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain outstanding results, then reprogram the region
  task automatic move_region(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    write_reg(CFG_LOW, lo);
    write_reg(CFG_HIGH, hi);
    cfg_valid <= 1'b0;
    cur_low  = lo;
    cur_high = hi;
  endtask

  task automatic random_request();
    int                r;
    int                span;
    logic [CPUF_W-1:0] who;
    span = region_pages();
    r    = $urandom_range(99);
    who  = CPUF_W'($urandom_range(7));
    if (r < 45)
      issue_request(CMD_ALLOC, who, $urandom());
    else if (r < 80)
      issue_request(CMD_FREE, who, free_target(span));
    else if (r < 88)
      issue_request(CMD_FREE, who, $urandom());
    else if (r < 94 && span <= 64)
      issue_request(CMD_INIT, who, $urandom());
    else if (r < 97)
      issue_request(CMD_NOP, who, $urandom());
    else
      issue_request(CMD_ALLOC, who, $urandom());
  endtask

  // small random region, now and then an arbitrary end
  task automatic random_phase(input int count);
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    longint unsigned   top_end;
    lo = $urandom();
    if ($urandom_range(1)) lo[PAGE_SHIFT-1:0] = '0;
    top_end = first_page(lo) + longint'($urandom_range(48)) * PG_BYTES
              + $urandom_range(int'(PG_BYTES) - 1);
    hi = (top_end > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(top_end);
    if ($urandom_range(7) == 0) hi = $urandom();
    move_region(lo, hi);
    repeat (count) random_request();
  endtask

  initial begin : stimulus
    rst       = 1'b1;
    req_valid = 1'b0;
    cmd       = CMD_ALLOC;
    cpu       = '0;
    page_addr = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LOW;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender busy, receiver mostly stalled
    tx_idle_pct = 26;
    rx_idle_pct = 80;

    // unaligned start, 20 whole pages and a partial one
    move_region(32'h8000_0123, 32'h8001_5800);
    issue_request(CMD_ALLOC, 3'd0, 32'h0);             // every list empty
    issue_request(CMD_NOP, 3'd7, 32'hFFFF_FFFF);
    issue_request(CMD_FREE, 3'd2, 32'h8000_1000);      // lowest page
    issue_request(CMD_ALLOC, 3'd2, 32'h0);             // list back to empty
    issue_request(CMD_INIT, 3'd3, 32'h0);
    issue_request(CMD_ALLOC, 3'd3, 32'h0);
    issue_request(CMD_ALLOC, 3'd5, 32'h0);             // steal from list 3
    issue_request(CMD_FREE, 3'd4, 32'h8000_1010);      // misaligned
    issue_request(CMD_FREE, 3'd4, 32'h8000_0000);      // below region start
    issue_request(CMD_FREE, 3'd4, 32'h8001_6000);      // past region end
    issue_request(CMD_FREE, 3'd4, 32'h8001_5000);      // last whole page boundary
    issue_request(CMD_FREE, 3'd6, 32'h8000_2000);
    issue_request(CMD_FREE, 3'd6, 32'h8000_2000);      // double free goes through
    issue_request(CMD_ALLOC, 3'd6, 32'h0);
    issue_request(CMD_ALLOC, 3'd6, 32'h0);
    issue_request(CMD_FREE, 3'd1, 32'h0000_0000);
    issue_request(CMD_FREE, 3'd1, 32'hFFFF_F000);
    issue_request(CMD_INIT, 3'd3, 32'h0);              // stacks on what is left
    for (int c = 0; c < 8; c++) issue_request(CMD_ALLOC, CPUF_W'(c), $urandom());

    repeat (3) random_phase(150);
    move_region(32'h0, 32'h0);                          // empty region
    repeat (20) random_request();

    // Sender sparse, receiver mostly ready
    tx_idle_pct = 80;
    rx_idle_pct = 26;
    repeat (3) random_phase(150);
    move_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);          // base rounds past 32 bits
    repeat (20) random_request();
    move_region(32'hFFFF_0001, 32'hFFFF_FFFF);          // pages at the top of memory
    repeat (60) random_request();

    // Full rate
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (3) random_phase(150);

    // whole address space: init stops at the page count limit
    move_region(32'h0, 32'hFFFF_FFFF);
    issue_request(CMD_INIT, 3'd1, 32'h0);
    issue_request(CMD_FREE, 3'd0, 32'h07FF_F000);      // last page index
    issue_request(CMD_FREE, 3'd0, 32'h0800_0000);      // one past the page count
    issue_request(CMD_FREE, 3'd0, 32'hFFFF_F000);
    issue_request(CMD_ALLOC, 3'd0, 32'h0);
    issue_request(CMD_ALLOC, 3'd2, 32'h0);
    issue_request(CMD_ALLOC, 3'd1, 32'h0);

    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
